// ===== sv/nsd_pkg.sv =====
// Types, constants and codes shared by the second-derivative block.
`timescale 1ns / 1ps
package nsd_pkg;
	localparam int MAX_POINTS = 65536;
	localparam int FRACTION_BITS = 16;
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int DATA_W = 32;
	localparam int NUM_W = 2 * DATA_W;
	localparam int DEN_W = DATA_W + 2;
	localparam int QUO_W = 63;
	localparam int CAP_W = 62;
	localparam int DIV_STEPS = NUM_W;
	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam int SLOPE_SHIFT = 2 * FRACTION_BITS;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_POINTS - 1);
	localparam logic [CAP_W-1:0] SLOPE_CAP = CAP_W'(1) << 61;
	localparam logic [CAP_W-1:0] TERM_CAP = CAP_W'(1) << 40;
	localparam logic [CAP_W-1:0] RES_CAP_POS = CAP_W'(32'h7FFF_FFFF);
	localparam logic [CAP_W-1:0] RES_CAP_NEG = CAP_W'(32'h8000_0000);

	localparam logic REG_BC_LEFT = 1'b0;
	localparam logic REG_BC_RIGHT = 1'b1;

	typedef enum logic [1:0] {
		BC_DIRICHLET = 2'd0,
		BC_NEUMANN   = 2'd1,
		BC_LINEAR    = 2'd2,
		BC_ZERO      = 2'd3
	} bc_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_ZERO = 2'd2,
		ST_FEW  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		JOB_INT,
		JOB_LEFT,
		JOB_RIGHT
	} job_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TP_GO0,
		S_TP_W0,
		S_TP_GO1,
		S_TP_W1,
		S_TP_GO2,
		S_TP_W2,
		S_EX_MUL,
		S_EX_GO,
		S_EX_W,
		S_EX_ADD,
		S_END,
		S_RES,
		S_EMIT_END,
		S_EMIT_INT,
		S_EMIT_FEW
	} state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic             neg;
		logic [CAP_W-1:0] cap;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [QUO_W-1:0] quo;
		logic                    sat;
	} div_rsp_t;
endpackage

// ===== sv/nsd_if.sv =====
// Channel interfaces: mesh points, results and configuration writes.
`timescale 1ns / 1ps
interface nsd_pt_if import nsd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] position;
	logic signed [DATA_W-1:0] sample_value;
	logic                     last_point;
	modport source(output valid, position, sample_value, last_point, input ready);
	modport sink(input valid, position, sample_value, last_point, output ready);
endinterface

interface nsd_res_if import nsd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [IDX_W-1:0]         point_index;
	logic signed [DATA_W-1:0] derivative;
	logic [1:0]               status;
	logic                     last_result;
	modport source(output valid, point_index, derivative, status, last_result, input ready);
	modport sink(input valid, point_index, derivative, status, last_result, output ready);
endinterface

interface nsd_cfg_if import nsd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       index;
	logic [1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/nsd_div.sv =====
// Shared restoring divider, one quotient bit a cycle, with magnitude clamp and sign.
`timescale 1ns / 1ps
module nsd_div import nsd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic              busy_q, fin_q;
	logic [STEP_W-1:0] cnt_q;
	logic [NUM_W-1:0]  num_q, quo_q;
	logic [DEN_W-1:0]  rem_q, den_q, rem_d;
	logic              neg_q;
	logic [CAP_W-1:0]  cap_q, qm;
	logic [DEN_W:0]    trial;
	logic              ge, over;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge = trial >= {1'b0, den_q};
	assign rem_d = ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			rem_q <= '0;
			quo_q <= '0;
			den_q <= req.den;
			neg_q <= req.neg;
			cap_q <= req.cap;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= rem_d;
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign over = quo_q > NUM_W'(cap_q);
	assign qm = over ? cap_q : quo_q[CAP_W-1:0];
	assign rsp.done = fin_q;
	assign rsp.sat = over;
	assign rsp.quo = neg_q ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
endmodule

// ===== sv/nonuniform_second_derivative.sv =====
// Streaming second derivative on a non-uniform mesh, top level.
//
//  channel | dir | payload                                            | beat
//  pts     | in  | position, sample_value, last_point                 | valid & ready
//  res     | out | point_index, derivative, status, last_result       | valid & ready
//  cfg     | in  | index (0 bc_left, 1 bc_right), data                | valid & ready
//
// One shared divider does every quotient, and a three-point term takes three of them.
// The fourth point adds the left end term, and the last point adds the right end term.
// pts is ready only while the sequencer is idle; each result waits in an
// output register, and the sequencer stalls while that register is full.
// arst_n clears control, the point count and both end modes.
`timescale 1ns / 1ps
module nonuniform_second_derivative import nsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	nsd_pt_if.sink    pts,
	nsd_res_if.source res,
	nsd_cfg_if.sink   cfg
);
	state_t state_q, state_d;
	job_t   job_q;
	bc_t    bc_left_q, bc_right_q, mode;

	logic [IDX_W-1:0]         cnt_q, k_q;
	logic                     last_q, last_in, acc, res_free, out_load;
	logic signed [DATA_W-1:0] xw_q [4];
	logic signed [DATA_W-1:0] fw_q [4];
	logic signed [DATA_W-1:0] rec_q [2];
	logic signed [QUO_W-1:0]  s0_q, s1_q;
	logic                     sat_q;
	logic signed [DATA_W-1:0] rv_q, dint_v_q;
	status_t                  rst_q, dint_st_q;
	logic [NUM_W-1:0]         prod_q;

	logic                     ov_q;
	logic [IDX_W-1:0]         oidx_q, oidx_d;
	logic signed [DATA_W-1:0] oval_q, oval_d;
	status_t                  ost_q, ost_d;
	logic                     olast_q, olast_d;

	div_req_t dreq;
	div_rsp_t drsp;

	logic signed [DATA_W:0]   df0, df1, h, hd, hn, ex_a;
	logic signed [DATA_W+2:0] d10, d21, d20;
	logic signed [DATA_W-1:0] fa, fc, base, other;
	logic signed [DATA_W+1:0] ex_ap;
	logic [DATA_W+2:0]        m10, m21, m20;
	logic [DATA_W:0]          mdf0, mdf1, mhd, mhn;
	logic [DATA_W+1:0]        map;
	logic signed [NUM_W-1:0]  sdiff;
	logic [NUM_W-1:0]         msd;
	logic                     tp_zero;
	logic signed [42:0]       ex_sum;
	logic signed [DATA_W-1:0] ex_res;
	logic                     ex_sat;

	nsd_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign acc = pts.valid && pts.ready;
	assign last_in = pts.last_point || (cnt_q == LAST_IDX);
	assign res_free = !ov_q || res.ready;
	assign pts.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign mode = (job_q == JOB_LEFT) ? bc_left_q : bc_right_q;

	// three-point operands
	always_comb begin
		fa = (bc_left_q == BC_NEUMANN) ? fw_q[0] : '0;
		fc = (bc_right_q == BC_NEUMANN) ? fw_q[3] : '0;
		h = '0;
		case (job_q)
			JOB_LEFT: begin
				h = 33'(xw_q[1]) - 33'(xw_q[0]);
				df0 = 33'(fw_q[0]) - 33'(fa);
				df1 = 33'(fw_q[1]) - 33'(fw_q[0]);
				d10 = 35'(h);
				d21 = 35'(h);
				d20 = 35'(h) + 35'(h);
			end
			JOB_RIGHT: begin
				h = 33'(xw_q[3]) - 33'(xw_q[2]);
				df0 = 33'(fw_q[3]) - 33'(fw_q[2]);
				df1 = 33'(fc) - 33'(fw_q[3]);
				d10 = 35'(h);
				d21 = 35'(h);
				d20 = 35'(h) + 35'(h);
			end
			default: begin
				df0 = 33'(fw_q[2]) - 33'(fw_q[1]);
				df1 = 33'(fw_q[3]) - 33'(fw_q[2]);
				d10 = 35'(xw_q[2]) - 35'(xw_q[1]);
				d21 = 35'(xw_q[3]) - 35'(xw_q[2]);
				d20 = 35'(xw_q[3]) - 35'(xw_q[1]);
			end
		endcase
		m10 = d10[DATA_W+2] ? 35'(-d10) : 35'(d10);
		m21 = d21[DATA_W+2] ? 35'(-d21) : 35'(d21);
		m20 = d20[DATA_W+2] ? 35'(-d20) : 35'(d20);
		mdf0 = df0[DATA_W] ? 33'(-df0) : 33'(df0);
		mdf1 = df1[DATA_W] ? 33'(-df1) : 33'(df1);
		tp_zero = (d10 == '0) || (d21 == '0) || (d20 == '0);
		sdiff = 64'(s1_q) - 64'(s0_q);
		msd = sdiff[NUM_W-1] ? 64'(-sdiff) : 64'(sdiff);
	end

	// linear end operands
	always_comb begin
		base = (job_q == JOB_LEFT) ? rec_q[0] : rec_q[1];
		other = (job_q == JOB_LEFT) ? rec_q[1] : rec_q[0];
		hn = (job_q == JOB_LEFT) ? 33'(xw_q[1]) - 33'(xw_q[0])
		                         : 33'(xw_q[3]) - 33'(xw_q[2]);
		hd = 33'(xw_q[2]) - 33'(xw_q[1]);
		ex_a = 33'(base) - 33'(other);
		ex_ap = hn[DATA_W] ? 34'(-34'(ex_a)) : 34'(ex_a);
		map = ex_ap[DATA_W+1] ? 34'(-ex_ap) : 34'(ex_ap);
		mhn = hn[DATA_W] ? 33'(-hn) : 33'(hn);
		mhd = hd[DATA_W] ? 33'(-hd) : 33'(hd);
		ex_sum = 43'(base) + s0_q[42:0];
		ex_sat = 1'b0;
		if (ex_sum > 43'sh7FFF_FFFF) begin
			ex_res = 32'sh7FFF_FFFF;
			ex_sat = 1'b1;
		end else if (ex_sum < -43'sh8000_0000) begin
			ex_res = 32'sh8000_0000;
			ex_sat = 1'b1;
		end else begin
			ex_res = ex_sum[DATA_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (acc) begin
				if (cnt_q < IDX_W'(3) && last_in) state_d = S_EMIT_FEW;
				else if (cnt_q >= IDX_W'(2)) state_d = S_TP_GO0;
			end
			S_TP_GO0: state_d = tp_zero ? S_RES : S_TP_W0;
			S_TP_W0: if (drsp.done) state_d = S_TP_GO1;
			S_TP_GO1: state_d = S_TP_W1;
			S_TP_W1: if (drsp.done) state_d = S_TP_GO2;
			S_TP_GO2: state_d = S_TP_W2;
			S_TP_W2: if (drsp.done) state_d = S_RES;
			S_EX_MUL: state_d = (hd == '0) ? S_RES : S_EX_GO;
			S_EX_GO: state_d = S_EX_W;
			S_EX_W: if (drsp.done) state_d = S_EX_ADD;
			S_EX_ADD: state_d = S_RES;
			S_END: begin
				case (mode)
					BC_DIRICHLET, BC_NEUMANN: state_d = S_TP_GO0;
					BC_LINEAR: state_d = S_EX_MUL;
					default: state_d = S_RES;
				endcase
			end
			S_RES: begin
				if (job_q == JOB_INT) state_d = (k_q == IDX_W'(3)) ? S_END : S_EMIT_INT;
				else state_d = S_EMIT_END;
			end
			S_EMIT_END: if (res_free) state_d = (job_q == JOB_LEFT) ? S_EMIT_INT : S_IDLE;
			S_EMIT_INT: if (res_free) state_d = last_q ? S_END : S_IDLE;
			S_EMIT_FEW: if (res_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		dreq = '0;
		out_load = 1'b0;
		oidx_d = '0;
		oval_d = '0;
		ost_d = ST_OK;
		olast_d = 1'b0;
		unique case (state_q)
			S_TP_GO0: begin
				dreq.start = !tp_zero;
				dreq.num = {mdf0[DATA_W-1:0], {SLOPE_SHIFT{1'b0}}};
				dreq.den = m10[DEN_W-1:0];
				dreq.neg = df0[DATA_W] ^ d10[DATA_W+2];
				dreq.cap = SLOPE_CAP;
			end
			S_TP_GO1: begin
				dreq.start = 1'b1;
				dreq.num = {mdf1[DATA_W-1:0], {SLOPE_SHIFT{1'b0}}};
				dreq.den = m21[DEN_W-1:0];
				dreq.neg = df1[DATA_W] ^ d21[DATA_W+2];
				dreq.cap = SLOPE_CAP;
			end
			S_TP_GO2: begin
				dreq.start = 1'b1;
				dreq.num = {msd[NUM_W-2:0], 1'b0};
				dreq.den = m20[DEN_W-1:0];
				dreq.neg = sdiff[NUM_W-1] ^ d20[DATA_W+2];
				dreq.cap = dreq.neg ? RES_CAP_NEG : RES_CAP_POS;
			end
			S_EX_GO: begin
				dreq.start = 1'b1;
				dreq.num = prod_q;
				dreq.den = DEN_W'(mhd);
				dreq.neg = ex_ap[DATA_W+1] ^ hd[DATA_W];
				dreq.cap = TERM_CAP;
			end
			S_EMIT_END: begin
				out_load = res_free;
				oidx_d = (job_q == JOB_LEFT) ? '0 : k_q;
				oval_d = rv_q;
				ost_d = rst_q;
				olast_d = (job_q == JOB_RIGHT);
			end
			S_EMIT_INT: begin
				out_load = res_free;
				oidx_d = k_q - 1'b1;
				oval_d = dint_v_q;
				ost_d = dint_st_q;
			end
			S_EMIT_FEW: begin
				out_load = res_free;
				ost_d = ST_FEW;
				olast_d = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			ov_q <= 1'b0;
			bc_left_q <= BC_DIRICHLET;
			bc_right_q <= BC_DIRICHLET;
		end else begin
			state_q <= state_d;
			if (acc) cnt_q <= last_in ? '0 : cnt_q + 1'b1;
			if (out_load) ov_q <= 1'b1;
			else if (res.ready) ov_q <= 1'b0;
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_BC_LEFT) bc_left_q <= bc_t'(cfg.data);
				if (cfg.index == REG_BC_RIGHT) bc_right_q <= bc_t'(cfg.data);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < 3; i++) begin
				xw_q[i] <= xw_q[i+1];
				fw_q[i] <= fw_q[i+1];
			end
			xw_q[3] <= pts.position;
			fw_q[3] <= pts.sample_value;
			k_q <= cnt_q;
			last_q <= last_in;
			job_q <= JOB_INT;
		end
		if (out_load) begin
			oidx_q <= oidx_d;
			oval_q <= oval_d;
			ost_q <= ost_d;
			olast_q <= olast_d;
		end
		unique case (state_q)
			S_TP_GO0: begin
				sat_q <= 1'b0;
				if (tp_zero) begin
					rv_q <= '0;
					rst_q <= ST_ZERO;
				end
			end
			S_TP_W0: if (drsp.done) begin
				s0_q <= drsp.quo;
				sat_q <= sat_q | drsp.sat;
			end
			S_TP_W1: if (drsp.done) begin
				s1_q <= drsp.quo;
				sat_q <= sat_q | drsp.sat;
			end
			S_TP_W2: if (drsp.done) begin
				rv_q <= drsp.quo[DATA_W-1:0];
				rst_q <= (sat_q | drsp.sat) ? ST_SAT : ST_OK;
			end
			S_EX_MUL: begin
				prod_q <= map[DATA_W-1:0] * mhn[DATA_W-1:0];
				if (hd == '0) begin
					rv_q <= '0;
					rst_q <= ST_ZERO;
				end
			end
			S_EX_W: if (drsp.done) begin
				s0_q <= drsp.quo;
				sat_q <= drsp.sat;
			end
			S_EX_ADD: begin
				rv_q <= ex_res;
				rst_q <= (sat_q | ex_sat) ? ST_SAT : ST_OK;
			end
			S_END: if (mode == BC_ZERO) begin
				rv_q <= '0;
				rst_q <= ST_OK;
			end
			S_RES: if (job_q == JOB_INT) begin
				rec_q[0] <= rec_q[1];
				rec_q[1] <= rv_q;
				dint_v_q <= rv_q;
				dint_st_q <= rst_q;
				if (k_q == IDX_W'(3)) job_q <= JOB_LEFT;
			end
			S_EMIT_INT: if (res_free && last_q) job_q <= JOB_RIGHT;
			default: ;
		endcase
	end

	assign res.valid = ov_q;
	assign res.point_index = oidx_q;
	assign res.derivative = oval_q;
	assign res.status = ost_q;
	assign res.last_result = olast_q;
endmodule

// ===== sv/nsd_chk.sv =====
// Port-level checker for the second-derivative block, bound to the top level.
`timescale 1ns / 1ps
module nsd_chk import nsd_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     pts_valid,
	input logic                     pts_ready,
	input logic                     pts_last,
	input logic                     res_valid,
	input logic                     res_ready,
	input logic [IDX_W-1:0]         res_index,
	input logic signed [DATA_W-1:0] res_value,
	input logic [1:0]               res_status,
	input logic                     res_last
);
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		pts_valid && pts_ready && pts_last |=> !pts_ready)
		else $error("point input ready right after a last point");

	a_few_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == ST_FEW |-> res_last && res_index == '0 && res_value == '0)
		else $error("too-few-points result malformed");

	a_zero_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == ST_ZERO |-> res_value == '0)
		else $error("zero-spacing result not zero");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_index) && $stable(res_value)
		&& $stable(res_status) && $stable(res_last))
		else $error("stalled result beat changed");
endmodule

bind nonuniform_second_derivative nsd_chk u_nsd_chk (
	.clk(clk),
	.arst_n(arst_n),
	.pts_valid(pts.valid),
	.pts_ready(pts.ready),
	.pts_last(pts.last_point),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_index(res.point_index),
	.res_value(res.derivative),
	.res_status(res.status),
	.res_last(res.last_result)
);

// ===== verif/nonuniform_second_derivative_tb.sv =====
// Self-checking testbench for the non-uniform mesh second-derivative block.
`timescale 1ns / 1ps
module nonuniform_second_derivative_tb;
	import nsd_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE = 1000;
	localparam int HOLD_CYCLES = 3000;

	typedef struct {
		logic signed [DATA_W-1:0] position;
		logic signed [DATA_W-1:0] sample_value;
		logic                     last_point;
	} point_t;

	typedef struct {
		logic [IDX_W-1:0]  point_index;
		logic [DATA_W-1:0] derivative;
		status_t           status;
		logic              last_result;
	} deriv_t;

	typedef struct {
		longint  v;
		status_t st;
	} curv_t;

	logic clk;
	logic arst_n;

	nsd_pt_if  pts();
	nsd_res_if res();
	nsd_cfg_if cfg();

	nonuniform_second_derivative dut (
		.clk(clk),
		.arst_n(arst_n),
		.pts(pts),
		.res(res),
		.cfg(cfg)
	);

	point_t pending_points[$];
	deriv_t expected_derivs[$];
	int     errors = 0;
	int     pts_taken = 0;
	int     idle_cycles = 0;

	// mirror of the block's state
	bc_t         mode_left, mode_right;
	longint      xw[4], fw[4];
	int unsigned npts;
	longint      interior_hist[2];
	bit          clamp_hit;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic longint unsigned mag(longint a);
		return a < 0 ? longint'(0) - a : a;
	endfunction

	// floor(n*m/d) clamped at cap
	function automatic longint unsigned scaled_quot(longint unsigned n, longint unsigned m,
			longint unsigned d, longint unsigned cap);
		longint unsigned qn = n / d;
		longint unsigned rn = n % d;
		longint unsigned q = 0;
		longint unsigned r = 0;
		for (int i = 63; i >= 0; i--) begin
			q = 2 * q + (m[i] ? qn : 0);
			r = 2 * r + (m[i] ? rn : 0);
			while (r >= d) begin
				r -= d;
				q++;
			end
			if (q > cap) begin
				clamp_hit = 1'b1;
				return cap;
			end
		end
		return q;
	endfunction

	function automatic longint signed_quot(longint a, longint unsigned m, longint b,
			longint unsigned cpos, longint unsigned cneg);
		bit neg = (a < 0) != (b < 0);
		longint unsigned q;
		q = scaled_quot(mag(a), m, mag(b), neg ? cneg : cpos);
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic curv_t three_point(longint xa, longint xb, longint xc,
			longint fa, longint fb, longint fc);
		curv_t r = '{0, ST_OK};
		longint d10 = xb - xa;
		longint d21 = xc - xb;
		longint d20 = xc - xa;
		longint s0, s1;
		longint unsigned sc = 64'd1 << SLOPE_SHIFT;
		if (d10 == 0 || d21 == 0 || d20 == 0) begin
			r.st = ST_ZERO;
			return r;
		end
		clamp_hit = 1'b0;
		s0 = signed_quot(fb - fa, sc, d10, 64'd1 << 61, 64'd1 << 61);
		s1 = signed_quot(fc - fb, sc, d21, 64'd1 << 61, 64'd1 << 61);
		r.v = signed_quot(s1 - s0, 2, d20, 64'h7FFF_FFFF, 64'h8000_0000);
		r.st = clamp_hit ? ST_SAT : ST_OK;
		return r;
	endfunction

	function automatic curv_t extrapolate(longint base, longint other, longint hn, longint hd);
		curv_t r = '{0, ST_OK};
		longint a = base - other;
		longint t;
		if (hd == 0) begin
			r.st = ST_ZERO;
			return r;
		end
		if (hn < 0) a = -a;
		clamp_hit = 1'b0;
		t = signed_quot(a, mag(hn), hd, 64'd1 << 40, 64'd1 << 40);
		r.v = base + t;
		if (r.v > 64'sh7FFF_FFFF) begin
			r.v = 64'sh7FFF_FFFF;
			clamp_hit = 1'b1;
		end else if (r.v < -64'sh8000_0000) begin
			r.v = -64'sh8000_0000;
			clamp_hit = 1'b1;
		end
		r.st = clamp_hit ? ST_SAT : ST_OK;
		return r;
	endfunction

	function automatic curv_t end_term(bc_t mode, bit left);
		curv_t r = '{0, ST_OK};
		case (mode)
			BC_DIRICHLET, BC_NEUMANN: begin
				if (left)
					r = three_point(2 * xw[0] - xw[1], xw[0], xw[1],
						mode == BC_NEUMANN ? fw[0] : 0, fw[0], fw[1]);
				else
					r = three_point(xw[2], xw[3], 2 * xw[3] - xw[2],
						fw[2], fw[3], mode == BC_NEUMANN ? fw[3] : 0);
			end
			BC_LINEAR: begin
				if (left)
					r = extrapolate(interior_hist[0], interior_hist[1],
						xw[1] - xw[0], xw[2] - xw[1]);
				else
					r = extrapolate(interior_hist[1], interior_hist[0],
						xw[3] - xw[2], xw[2] - xw[1]);
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic void push_deriv(int unsigned idx, curv_t c, bit fin);
		deriv_t e;
		e.point_index = idx[IDX_W-1:0];
		e.derivative = c.v[DATA_W-1:0];
		e.status = c.st;
		e.last_result = fin;
		expected_derivs.push_back(e);
	endfunction

	function automatic void clear_mesh();
		for (int i = 0; i < 4; i++) begin
			xw[i] = 0;
			fw[i] = 0;
		end
		interior_hist[0] = 0;
		interior_hist[1] = 0;
		npts = 0;
	endfunction

	function automatic void predict_point(point_t p);
		int unsigned k = npts;
		bit fin = p.last_point || k >= MAX_POINTS - 1;
		curv_t d;
		for (int i = 0; i < 3; i++) begin
			xw[i] = xw[i+1];
			fw[i] = fw[i+1];
		end
		xw[3] = p.position;
		fw[3] = p.sample_value;
		if (k < 3 && fin) begin
			push_deriv(0, '{0, ST_FEW}, 1'b1);
			clear_mesh();
			return;
		end
		if (k >= 2) begin
			d = three_point(xw[1], xw[2], xw[3], fw[1], fw[2], fw[3]);
			interior_hist[0] = interior_hist[1];
			interior_hist[1] = d.v;
			if (k == 3) push_deriv(0, end_term(mode_left, 1'b1), 1'b0);
			push_deriv(k - 1, d, 1'b0);
		end
		if (fin) begin
			push_deriv(k, end_term(mode_right, 1'b0), 1'b1);
			clear_mesh();
		end else begin
			npts = k + 1;
		end
	endfunction

	// point driver: bursts with random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts.valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (pts.valid && pts.ready) begin
				predict_point('{pts.position, pts.sample_value, pts.last_point});
				pts_taken++;
			end
			if (!pts.valid || pts.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					pts.valid <= 1'b0;
				end else if (pending_points.size() > 0) begin
					point_t p;
					p = pending_points.pop_front();
					pts.position <= p.position;
					pts.sample_value <= p.sample_value;
					pts.last_point <= p.last_point;
					pts.valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
					end
				end else begin
					pts.valid <= 1'b0;
				end
			end
		end
	end

	// result receiver: stall pattern plus one long hold-off
	int stall_left = 0;
	int hold_left = 0;
	bit held_once = 0;
	int calm_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (!held_once && pts_taken >= 60) begin
				held_once = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res.ready <= 1'b0;
			end else begin
				if (calm_left > 0)
					calm_left--;
				else if ($urandom_range(0, 99) == 0)
					calm_left = $urandom_range(200, 2000);
				else if ($urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 400);
				res.ready <= 1'b1;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			if (expected_derivs.size() == 0) begin
				errors++;
				$display("%0t: unexpected result idx=%0d deriv=%h status=%0d last=%b", $time,
					res.point_index, res.derivative, res.status, res.last_result);
			end else begin
				deriv_t e;
				e = expected_derivs.pop_front();
				if (res.point_index !== e.point_index) begin
					errors++;
					$display("%0t: point_index expected %0d actual %0d", $time,
						e.point_index, res.point_index);
				end
				if (res.derivative !== e.derivative) begin
					errors++;
					$display("%0t: derivative idx %0d expected %h actual %h", $time,
						e.point_index, e.derivative, res.derivative);
				end
				if (res.status !== e.status) begin
					errors++;
					$display("%0t: status idx %0d expected %0d actual %0d", $time,
						e.point_index, e.status, res.status);
				end
				if (res.last_result !== e.last_result) begin
					errors++;
					$display("%0t: last_result idx %0d expected %b actual %b", $time,
						e.point_index, e.last_result, res.last_result);
				end
			end
		end
	end

	// watchdog on beats of any channel
	always @(posedge clk) begin
		if ((pts.valid && pts.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("nonuniform_second_derivative_tb failed");
			$finish;
		end
	end

	task automatic add_point(logic signed [31:0] x, logic signed [31:0] f, logic fin);
		pending_points.push_back('{x, f, fin});
	endtask

	task automatic wait_drained();
		while (!(pending_points.size() == 0 && !pts.valid && expected_derivs.size() == 0))
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, bc_t mode);
		@(posedge clk);
		cfg.index <= idx;
		cfg.data <= mode;
		cfg.valid <= 1'b1;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		if (idx == REG_BC_LEFT)
			mode_left = mode;
		else
			mode_right = mode;
	endtask

	task automatic add_mesh(int len);
		int x = $urandom;
		int f = $urandom;
		int sh = $urandom_range(0, 24);
		int fsh = $urandom_range(0, 31);
		for (int i = 0; i < len; i++) begin
			add_point(x, f, i == len - 1);
			if ($urandom_range(0, 40) == 0)
				x = x;
			else
				x = x + $urandom_range(1, 1 << sh);
			f = f + ($signed($urandom) >>> fsh);
		end
	endtask

	task automatic add_noise(int len);
		for (int i = 0; i < len; i++)
			add_point($urandom, $urandom, i == len - 1);
	endtask

	initial begin
		bc_t modes[8][2];
		int queued;
		pts.valid = 1'b0;
		pts.position = '0;
		pts.sample_value = '0;
		pts.last_point = 1'b0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_BC_LEFT;
		cfg.data = BC_DIRICHLET;
		mode_left = BC_DIRICHLET;
		mode_right = BC_DIRICHLET;
		clear_mesh();
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// too few points: one, two and three point meshes
		add_point(32'sh0001_0000, 32'sh0002_0000, 1'b1);
		add_point(0, 5, 1'b0);
		add_point(32'sh0001_0000, 7, 1'b1);
		add_point(0, 1, 1'b0);
		add_point(10, 2, 1'b0);
		add_point(20, 3, 1'b1);
		// plain four-point mesh, parabola
		add_point(0, 0, 1'b0);
		add_point(32'sh0001_0000, 32'sh0001_0000, 1'b0);
		add_point(32'sh0003_0000, 32'sh0009_0000, 1'b0);
		add_point(32'sh0004_0000, 32'sh0010_0000, 1'b1);
		// zero spacing
		add_point(100, 5, 1'b0);
		add_point(100, 9, 1'b0);
		add_point(200, -9, 1'b0);
		add_point(300, 1, 1'b1);
		// field extremes, saturation
		add_point(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
		add_point(32'sh8000_0001, 32'sh8000_0000, 1'b0);
		add_point(32'sh8000_0002, 32'sh7FFF_FFFF, 1'b0);
		add_point(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
		add_point(32'shFFFF_FFFF, -1, 1'b1);
		// decreasing positions
		add_point(32'sh0005_0000, 3, 1'b0);
		add_point(32'sh0003_0000, -40000, 1'b0);
		add_point(32'sh0002_8000, 12345, 1'b0);
		add_point(32'sh0000_0001, 0, 1'b1);
		wait_drained();

		modes = '{'{BC_NEUMANN, BC_NEUMANN}, '{BC_LINEAR, BC_LINEAR},
			'{BC_ZERO, BC_ZERO}, '{BC_LINEAR, BC_NEUMANN}, '{BC_DIRICHLET, BC_ZERO},
			'{BC_ZERO, BC_LINEAR}, '{BC_DIRICHLET, BC_DIRICHLET},
			'{BC_NEUMANN, BC_LINEAR}};
		foreach (modes[ph]) begin
			write_reg(REG_BC_LEFT, modes[ph][0]);
			write_reg(REG_BC_RIGHT, modes[ph][1]);
			queued = 0;
			while (queued < 32) begin
				int len;
				if ($urandom_range(0, 9) == 0) begin
					len = $urandom_range(1, 6);
					add_noise(len);
				end else begin
					len = $urandom_range(4, 12);
					add_mesh(len);
				end
				queued += len;
			end
			wait_drained();
		end

		if (errors == 0)
			$display("nonuniform_second_derivative_tb passed");
		else
			$display("nonuniform_second_derivative_tb failed");
		$finish;
	end
endmodule

// ===== sim.f =====
sv/nsd_pkg.sv
sv/nsd_if.sv
sv/nsd_div.sv
sv/nonuniform_second_derivative.sv
sv/nsd_chk.sv
verif/nonuniform_second_derivative_tb.sv
